// ----- hw/rtl/kct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_pkg: keyed count table package
// Sizes, status codes and the cell control type shared by the table files.
// ----------------------------------------------------------------------------
package kct_pkg;

    localparam int TABLE_SLOTS = 16;   // 2 .. 16
    localparam int KEY_CHARS   = 8;    // 1 .. 8

    localparam int KEY_W    = 64;
    localparam int KEY_BITS = 8 * KEY_CHARS;
    localparam int AMT_W    = 16;
    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int TOTAL_W  = $clog2(TABLE_SLOTS + 1);

    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 4;
    localparam int TOTAL_OUT_W = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_ZERO   = 3'd1,
        ST_FULL   = 3'd2,
        ST_ABSENT = 3'd3,
        ST_SHORT  = 3'd4
    } t_status;

    // per-cell write controls, at most one set in a cycle
    typedef struct packed {
        logic load_new;     // take request key and write count
        logic load_count;   // take write count, keep key
        logic shift_in;     // take key and count from upper neighbour
    } t_cell_ctl;

endpackage

// ----- hw/rtl/kct_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_req_if: request channel
// Valid/ready channel carrying one add or remove request item.
// ----------------------------------------------------------------------------
interface kct_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [kct_pkg::KEY_W-1:0]  item_key;
    logic [kct_pkg::AMT_W-1:0]  amount;

    modport source (output valid, req_type, item_key, amount, input ready);
    modport sink   (input valid, req_type, item_key, amount, output ready);
endinterface

// ----- hw/rtl/kct_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_rsp_if: result channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
interface kct_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [kct_pkg::STATUS_W-1:0]     status;
    logic [kct_pkg::SLOT_OUT_W-1:0]   slot_index;
    logic [kct_pkg::AMT_W-1:0]        new_count;
    logic [kct_pkg::TOTAL_OUT_W-1:0]  entry_total;

    modport source (output valid, status, slot_index, new_count, entry_total,
                    input ready);
    modport sink   (input valid, status, slot_index, new_count, entry_total,
                    output ready);
endinterface

// ----- hw/rtl/kct_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_cell: one table slot
// Holds one key and count, compares the key, takes data from its neighbour.
// ----------------------------------------------------------------------------
module kct_cell (
    input  logic                         i_clk,
    input  logic [kct_pkg::KEY_BITS-1:0] i_cmp_key,
    input  kct_pkg::t_cell_ctl           i_ctl,
    input  logic [kct_pkg::AMT_W-1:0]    i_wr_count,
    input  logic [kct_pkg::KEY_BITS-1:0] i_next_key,
    input  logic [kct_pkg::AMT_W-1:0]    i_next_count,
    output logic                         o_key_eq,
    output logic [kct_pkg::KEY_BITS-1:0] o_key,
    output logic [kct_pkg::AMT_W-1:0]    o_count
);

    logic [kct_pkg::KEY_BITS-1:0] r_key;
    logic [kct_pkg::AMT_W-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.shift_in) begin
            r_key   <= i_next_key;
            r_count <= i_next_count;
        end else if (i_ctl.load_new) begin
            r_key   <= i_cmp_key;
            r_count <= i_wr_count;
        end else if (i_ctl.load_count) begin
            r_count <= i_wr_count;
        end else begin
            // no write: hold
            r_key   <= r_key;
            r_count <= r_count;
        end
    end

    assign o_key_eq = (r_key == i_cmp_key);
    assign o_key    = r_key;
    assign o_count  = r_count;

endmodule

// ----- hw/rtl/keyed_count_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_count_table_unit: keyed count table
// Packed, insertion-ordered table of (key, count) entries in a row of cells.
// ----------------------------------------------------------------------------
// Each request item is taken in S_IDLE and applied in S_APPLY. In the cycle
// it is accepted, every cell compares its key with the request key at once
// and the hit slot and its count are registered. In S_APPLY the table is
// updated (count write, append at the fill level, or a one-step shift of all
// later cells down by one slot when a count reaches zero) and the result item
// is loaded into the output register. S_APPLY stretches while the output
// register still holds an earlier result that has not been taken. A request
// is accepted in any idle cycle, also while a result waits. Only the low
// 8*KEY_CHARS bits of the key are compared and stored. Slot contents are
// undefined after reset; the fill count alone says which slots are live,
// so no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_count_table_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kct_req_if.sink   i_req,
    kct_rsp_if.source o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } t_state;

    t_state r_state, n_state;

    // fill level and registered request
    logic [kct_pkg::TOTAL_W-1:0]  r_used, n_used;
    logic                         r_req_type;
    logic [kct_pkg::KEY_BITS-1:0] r_key;
    logic [kct_pkg::AMT_W-1:0]    r_amount;

    // registered compare outcome
    logic [kct_pkg::TABLE_SLOTS-1:0] r_hit_vec;
    logic                            r_hit;
    logic [kct_pkg::SLOT_W-1:0]      r_hit_idx;
    logic [kct_pkg::AMT_W-1:0]       r_hit_count;

    // result register
    logic                             r_rsp_valid;
    logic [kct_pkg::STATUS_W-1:0]     r_status;
    logic [kct_pkg::SLOT_OUT_W-1:0]   r_slot;
    logic [kct_pkg::AMT_W-1:0]        r_count_out;
    logic [kct_pkg::TOTAL_OUT_W-1:0]  r_total;

    // cell row; the extra top entry feeds the last cell's shift input
    logic [kct_pkg::KEY_BITS-1:0]    cell_key   [kct_pkg::TABLE_SLOTS+1];
    logic [kct_pkg::AMT_W-1:0]       cell_count [kct_pkg::TABLE_SLOTS+1];
    logic [kct_pkg::TABLE_SLOTS-1:0] cell_eq;
    logic [kct_pkg::TABLE_SLOTS-1:0] hit_vec;
    kct_pkg::t_cell_ctl              cell_ctl   [kct_pkg::TABLE_SLOTS];

    logic [kct_pkg::KEY_BITS-1:0] cmp_key;
    logic                         accept;
    logic                         apply_go;
    logic [kct_pkg::SLOT_W-1:0]   hit_idx;
    logic [kct_pkg::AMT_W-1:0]    hit_count;

    // update decode
    logic [kct_pkg::AMT_W:0]      cnt_sum;
    logic [kct_pkg::AMT_W-1:0]    cnt_sat;
    logic [kct_pkg::AMT_W-1:0]    cnt_diff;
    logic                         upd_count;
    logic                         do_append;
    logic                         do_shift;
    logic [kct_pkg::AMT_W-1:0]    wr_count;
    kct_pkg::t_status             res_status;
    logic [kct_pkg::SLOT_W-1:0]   res_slot;
    logic [kct_pkg::AMT_W-1:0]    res_count;

    assign accept   = i_req.valid && i_req.ready;
    assign apply_go = (r_state == S_APPLY) && (!r_rsp_valid || o_rsp.ready);

    // compare against the live request in the accept cycle, against the
    // held key while updating (new key written from it on append)
    assign cmp_key = (r_state == S_APPLY) ? r_key
                                          : i_req.item_key[kct_pkg::KEY_BITS-1:0];

    assign cell_key[kct_pkg::TABLE_SLOTS]   = '0;
    assign cell_count[kct_pkg::TABLE_SLOTS] = '0;

    for (genvar i = 0; i < kct_pkg::TABLE_SLOTS; i++) begin : g_cell
        // a cell only counts as a hit below the fill level
        assign hit_vec[i] = cell_eq[i] && (kct_pkg::TOTAL_W'(i) < r_used);

        assign cell_ctl[i].load_count = apply_go && upd_count && r_hit_vec[i];
        assign cell_ctl[i].load_new   = apply_go && do_append
                                        && (r_used == kct_pkg::TOTAL_W'(i));
        assign cell_ctl[i].shift_in   = apply_go && do_shift
                                        && (kct_pkg::SLOT_W'(i) >= r_hit_idx)
                                        && (kct_pkg::TOTAL_W'(i + 1) < r_used);

        kct_cell u_cell (
            .i_clk        (i_clk),
            .i_cmp_key    (cmp_key),
            .i_ctl        (cell_ctl[i]),
            .i_wr_count   (wr_count),
            .i_next_key   (cell_key[i+1]),
            .i_next_count (cell_count[i+1]),
            .o_key_eq     (cell_eq[i]),
            .o_key        (cell_key[i]),
            .o_count      (cell_count[i])
        );
    end

    // live keys are unique, so at most one hit: OR-select index and count
    always_comb begin
        hit_idx   = '0;
        hit_count = '0;
        for (int i = 0; i < kct_pkg::TABLE_SLOTS; i++) begin
            if (hit_vec[i]) begin
                hit_idx   = hit_idx | kct_pkg::SLOT_W'(i);
                hit_count = hit_count | cell_count[i];
            end
        end
    end

    // decision for the update cycle
    always_comb begin
        cnt_sum    = {1'b0, r_hit_count} + {1'b0, r_amount};
        cnt_sat    = cnt_sum[kct_pkg::AMT_W] ? '1 : cnt_sum[kct_pkg::AMT_W-1:0];
        cnt_diff   = r_hit_count - r_amount;
        upd_count  = 1'b0;
        do_append  = 1'b0;
        do_shift   = 1'b0;
        wr_count   = r_amount;
        res_status = kct_pkg::ST_OK;
        res_slot   = '0;
        res_count  = '0;
        n_used     = r_used;
        priority if (r_amount == '0) begin
            res_status = kct_pkg::ST_ZERO;
        end else if (!r_req_type && r_hit) begin
            upd_count = 1'b1;
            wr_count  = cnt_sat;
            res_slot  = r_hit_idx;
            res_count = cnt_sat;
        end else if (!r_req_type
                     && (r_used >= kct_pkg::TOTAL_W'(kct_pkg::TABLE_SLOTS))) begin
            res_status = kct_pkg::ST_FULL;
        end else if (!r_req_type) begin
            do_append = 1'b1;
            res_slot  = r_used[kct_pkg::SLOT_W-1:0];
            res_count = r_amount;
            n_used    = r_used + kct_pkg::TOTAL_W'(1);
        end else if (!r_hit) begin
            res_status = kct_pkg::ST_ABSENT;
        end else if (r_hit_count < r_amount) begin
            res_status = kct_pkg::ST_SHORT;
            res_count  = r_hit_count;
        end else if (cnt_diff == '0) begin
            // entry emptied: later cells close the gap
            do_shift = 1'b1;
            res_slot = r_hit_idx;
            n_used   = r_used - kct_pkg::TOTAL_W'(1);
        end else begin
            upd_count = 1'b1;
            wr_count  = cnt_diff;
            res_slot  = r_hit_idx;
            res_count = cnt_diff;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept)   n_state = S_APPLY;
            S_APPLY: if (apply_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (apply_go) begin
                r_used      <= n_used;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // request and compare outcome
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type  <= i_req.req_type;
            r_key       <= i_req.item_key[kct_pkg::KEY_BITS-1:0];
            r_amount    <= i_req.amount;
            r_hit_vec   <= hit_vec;
            r_hit       <= |hit_vec;
            r_hit_idx   <= hit_idx;
            r_hit_count <= hit_count;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (apply_go) begin
            r_status    <= res_status;
            r_slot      <= kct_pkg::SLOT_OUT_W'(res_slot);
            r_count_out <= res_count;
            r_total     <= kct_pkg::TOTAL_OUT_W'(n_used);
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.slot_index  = r_slot;
    assign o_rsp.new_count   = r_count_out;
    assign o_rsp.entry_total = r_total;

endmodule

// ----- dv/tb_keyed_count_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_count_table_unit: self-checking bench for the keyed count table
// Drives add/remove request items with random idling and a long result
// back-pressure stretch. Every result item is checked against a behavioural
// table model, which includes saturation, refusals and gap closing.
// ----------------------------------------------------------------------------
module tb_keyed_count_table_unit;
    import kct_pkg::*;

    // request kinds as carried in req_type
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
    localparam int POOL_KEYS   = 20;
    localparam int RAND_ITEMS  = 500;
    localparam int CALM_TAIL   = 80;     // final stretch without any idling
    localparam int HOLD_AT     = 150;    // items sent before the long stall
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amount;
    } t_req_item;

    typedef struct packed {
        t_status                status;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [AMT_W-1:0]       count;
        logic [TOTAL_OUT_W-1:0] total;
    } t_table_result;

    logic clk;
    logic rst_n     = 1'b0;
    logic hold_off  = 1'b0;

    // request side, driven from here and mirrored onto the interface
    logic             req_valid = 1'b0;
    logic             req_op    = OP_ADD;
    logic [KEY_W-1:0] req_key   = '0;
    logic [AMT_W-1:0] req_amt   = '0;
    logic             rsp_ready = 1'b0;

    kct_req_if req_ch ();
    kct_rsp_if rsp_ch ();

    assign req_ch.valid    = req_valid;
    assign req_ch.req_type = req_op;
    assign req_ch.item_key = req_key;
    assign req_ch.amount   = req_amt;
    assign rsp_ch.ready    = rsp_ready;

    keyed_count_table_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Shadow table: packed, insertion ordered, same as the block's cells
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] tbl_key [TABLE_SLOTS];
    logic [AMT_W-1:0] tbl_cnt [TABLE_SLOTS];
    int unsigned      tbl_used = 0;

    t_req_item     request_backlog [$];   // items still to be offered
    t_table_result due_results [$];       // predicted results, oldest first

    int total_items  = 0;
    int sent_cnt     = 0;
    int got_cnt      = 0;
    int mismatch_cnt = 0;
    int src_gap      = 0;
    int sink_gap     = 0;
    int status_hits [5];
    int peak_fill    = 0;
    int compactions  = 0;
    logic idle_ok;
    t_req_item drv_item;

    // idling allowed outside quiet windows and never near the end
    assign idle_ok = (sent_cnt < total_items - CALM_TAIL) && (((sent_cnt / 50) % 4) != 3);

    // Applies one request to the shadow table and returns the result item
    // the block should produce for it.
    function automatic t_table_result apply_to_table(t_req_item rq);
        t_table_result    res;
        logic [KEY_W-1:0] k;
        logic [AMT_W:0]   sum;
        int               hit;
        int               i;
        res        = '0;
        res.status = ST_OK;
        k          = rq.key & KEY_MASK;
        hit        = -1;
        if (rq.amount == '0) begin
            res.status = ST_ZERO;
        end else begin
            for (i = 0; i < int'(tbl_used); i++)
                if (hit < 0 && tbl_key[i] == k) hit = i;
            if (rq.op == OP_ADD) begin
                if (hit >= 0) begin
                    // saturate rather than wrap
                    sum          = {1'b0, tbl_cnt[hit]} + {1'b0, rq.amount};
                    tbl_cnt[hit] = sum[AMT_W] ? {AMT_W{1'b1}} : sum[AMT_W-1:0];
                    res.slot     = hit[SLOT_OUT_W-1:0];
                    res.count    = tbl_cnt[hit];
                end else if (tbl_used >= TABLE_SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    tbl_key[tbl_used] = k;
                    tbl_cnt[tbl_used] = rq.amount;
                    res.slot          = tbl_used[SLOT_OUT_W-1:0];
                    res.count         = rq.amount;
                    tbl_used++;
                end
            end else begin
                if (hit < 0) begin
                    res.status = ST_ABSENT;
                end else if (tbl_cnt[hit] < rq.amount) begin
                    // refused, but the current count is still reported
                    res.status = ST_SHORT;
                    res.count  = tbl_cnt[hit];
                end else begin
                    tbl_cnt[hit] = tbl_cnt[hit] - rq.amount;
                    res.slot     = hit[SLOT_OUT_W-1:0];
                    res.count    = tbl_cnt[hit];
                    if (tbl_cnt[hit] == '0) begin
                        // entry gone: later entries slide down one slot
                        for (i = hit; i + 1 < int'(tbl_used); i++) begin
                            tbl_key[i] = tbl_key[i+1];
                            tbl_cnt[i] = tbl_cnt[i+1];
                        end
                        tbl_used--;
                        compactions++;
                    end
                end
            end
        end
        if (int'(tbl_used) > peak_fill) peak_fill = int'(tbl_used);
        res.total = tbl_used[TOTAL_OUT_W-1:0];
        return res;
    endfunction

    // Mostly small amounts so counts fall back to zero; some zero, some
    // maximal and some fully random so every amount bit toggles.
    function automatic logic [AMT_W-1:0] pick_amount(logic op);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < (op == OP_ADD ? 9 : 13)) return {AMT_W{1'b1}};
        if (r < (op == OP_ADD ? 17 : 25)) return AMT_W'($urandom_range(0, 65535));
        return AMT_W'($urandom_range(1, 4));
    endfunction

    // lower-case name of 1..8 characters, first character in the low byte
    function automatic logic [KEY_W-1:0] make_name();
        logic [KEY_W-1:0] v;
        int               len;
        int               j;
        v   = '0;
        len = $urandom_range(1, 8);
        for (j = 0; j < len; j++)
            v[8*j +: 8] = 8'($urandom_range(97, 122));
        return v;
    endfunction

    task automatic queue_req(logic op, logic [KEY_W-1:0] key, logic [AMT_W-1:0] amt);
        t_req_item rq;
        rq.op     = op;
        rq.key    = key;
        rq.amount = amt;
        request_backlog.push_back(rq);
    endtask

    task automatic report_mismatch(string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus: directed opening, then random traffic over a key pool
    // ------------------------------------------------------------------
    initial begin
        logic [KEY_W-1:0] fill_keys [TABLE_SLOTS];
        logic [KEY_W-1:0] key_pool [POOL_KEYS];
        logic             op;
        logic [KEY_W-1:0] key;
        int               add_pct;
        int               n;

        for (n = 2; n < TABLE_SLOTS; n++)
            fill_keys[n] = (n % 2 == 0) ? make_name() : {$urandom, $urandom};

        // refusals on an empty table
        queue_req(OP_ADD,    {KEY_W{1'b1}}, '0);              // zero amount
        queue_req(OP_REMOVE, {KEY_W{1'b1}}, 16'd5);           // key absent
        // all-ones key, maximum amount, then saturation
        queue_req(OP_ADD,    {KEY_W{1'b1}}, {AMT_W{1'b1}});
        queue_req(OP_ADD,    {KEY_W{1'b1}}, 16'd1);
        // all-zero key, then a remove that is too large
        queue_req(OP_ADD,    '0, 16'd1);
        queue_req(OP_REMOVE, '0, 16'd2);
        queue_req(OP_REMOVE, {KEY_W{1'b1}}, '0);
        // fill every slot, then one more new key is refused
        for (n = 2; n < TABLE_SLOTS; n++)
            queue_req(OP_ADD, fill_keys[n], AMT_W'(n));
        queue_req(OP_ADD,    64'h0000_0000_7465_7374, 16'd3);
        // remove the head to zero: all later entries close the gap
        queue_req(OP_REMOVE, {KEY_W{1'b1}}, {AMT_W{1'b1}});
        // remove a middle entry to zero
        queue_req(OP_REMOVE, fill_keys[7], 16'd7);
        // zero key now at the head, fill it to the maximum count and drain it
        queue_req(OP_ADD,    '0, 16'd65534);
        queue_req(OP_REMOVE, '0, {AMT_W{1'b1}});

        for (n = 0; n < 8; n++) key_pool[n] = fill_keys[n+2];
        key_pool[8] = '0;
        key_pool[9] = {KEY_W{1'b1}};
        for (n = 10; n < 16; n++) key_pool[n] = make_name();
        for (n = 16; n < POOL_KEYS; n++) key_pool[n] = {$urandom, $urandom};

        // alternate add-heavy and remove-heavy spells so the table both
        // fills up and drains; a few keys come from outside the pool
        for (n = 0; n < RAND_ITEMS; n++) begin
            add_pct = ((n / 40) % 2 == 0) ? 75 : 35;
            op      = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_REMOVE;
            key     = ($urandom_range(0, 99) < 8) ? {$urandom, $urandom}
                                                  : key_pool[$urandom_range(0, POOL_KEYS-1)];
            queue_req(op, key, pick_amount(op));
        end
        total_items = request_backlog.size();
    end

    // ------------------------------------------------------------------
    // Request driver: holds an item until taken, idles in short bursts
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            src_gap   <= 0;
        end else if (!req_valid || req_ch.ready) begin
            if (src_gap != 0) begin
                src_gap   <= src_gap - 1;
                req_valid <= 1'b0;
            end else if (request_backlog.size() == 0) begin
                req_valid <= 1'b0;
            end else if (idle_ok && !hold_off && $urandom_range(0, 5) == 0) begin
                src_gap   <= $urandom_range(0, 9);
                req_valid <= 1'b0;
            end else begin
                drv_item   = request_backlog.pop_front();
                req_valid <= 1'b1;
                req_op    <= drv_item.op;
                req_key   <= drv_item.key;
                req_amt   <= drv_item.amount;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stall bursts, plus the long hold-off below
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            sink_gap  <= 0;
        end else if (hold_off) begin
            rsp_ready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap  <= sink_gap - 1;
            rsp_ready <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 6) == 0) begin
            sink_gap  <= $urandom_range(0, 9);
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= 1'b1;
        end
    end

    // long stall on the result side while requests keep coming, so the
    // block's output register and request stage both fill and it stalls
    initial begin
        while (sent_cnt < HOLD_AT) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on request accept, check on result accept
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_table_result want;
        if (rst_n) begin
            if (req_valid && req_ch.ready) begin
                due_results.push_back(apply_to_table({req_op, req_key, req_amt}));
                sent_cnt <= sent_cnt + 1;
            end
            if (rsp_ch.valid && rsp_ready) begin
                got_cnt <= got_cnt + 1;
                if (due_results.size() == 0) begin
                    report_mismatch("result item with no request outstanding");
                end else begin
                    want = due_results.pop_front();
                    status_hits[want.status]++;
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp_ch.status, want.status));
                    if (rsp_ch.slot_index !== want.slot)
                        report_mismatch($sformatf("slot_index got %0d want %0d",
                                                  rsp_ch.slot_index, want.slot));
                    if (rsp_ch.new_count !== want.count)
                        report_mismatch($sformatf("new_count got %0d want %0d",
                                                  rsp_ch.new_count, want.count));
                    if (rsp_ch.entry_total !== want.total)
                        report_mismatch($sformatf("entry_total got %0d want %0d",
                                                  rsp_ch.entry_total, want.total));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------
    initial begin
        while (!rst_n) @(posedge clk);
        while (sent_cnt != total_items) @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
        // run on to catch any stray result item
        repeat (20) @(posedge clk);
        $display("%0d requests, %0d results; ok %0d, zero %0d, full %0d, absent %0d, short %0d",
                 sent_cnt, got_cnt, status_hits[ST_OK], status_hits[ST_ZERO],
                 status_hits[ST_FULL], status_hits[ST_ABSENT], status_hits[ST_SHORT]);
        $display("peak fill %0d of %0d slots, %0d entries removed with gap closing",
                 peak_fill, TABLE_SLOTS, compactions);
        if (mismatch_cnt == 0) begin
            $display("PASS keyed_count_table_unit");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("FAIL keyed_count_table_unit");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(2_000_000);
        $display("timeout: %0d of %0d requests sent, %0d results", sent_cnt, total_items,
                 got_cnt);
        $display("FAIL keyed_count_table_unit");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/kct_pkg.sv
hw/rtl/kct_req_if.sv
hw/rtl/kct_rsp_if.sv
hw/rtl/kct_cell.sv
hw/rtl/keyed_count_table_unit.sv
dv/tb_keyed_count_table_unit.sv
